// ===== hw/rtl/pwbc_pkg.sv =====
// Package with the shared types and constants of the path wall blocking check.
`timescale 1ns / 1ps
package pwbc_pkg;

  localparam int MaxWalls  = 32;
  localparam int CoordBits = 16;
  localparam int CountBits = 6;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_V = 2'd0,
    ACT_LOAD_H = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]                  action;
    logic signed [CoordBits-1:0] seg_start_x;
    logic signed [CoordBits-1:0] seg_start_y;
    logic signed [CoordBits-1:0] seg_end_x;
    logic signed [CoordBits-1:0] seg_end_y;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 table_full;
    logic                 blocked;
    logic                 crosses_wall;
    logic                 behind_wall;
    logic [CountBits-1:0] vertical_count;
    logic [CountBits-1:0] horizontal_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_SCAN  = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

endpackage

// ===== hw/rtl/path_wall_blocking_check_top.sv =====
// Top level of the path wall blocking check.
`timescale 1ns / 1ps
// Loads and clears are answered by the back part in the cycle it takes them; their result
// goes through the input queue and the result queue to the result ports. A query scans the
// vertical table and then the horizontal table, one wall a cycle through a registered table
// read and a two-stage cross-product pipeline; its result is written to the result queue
// once the pipeline has drained and the result queue is not full. The front and result
// sides are short queues, so beats are taken while the back part is busy until the input
// queue fills. Table contents need no clearing after reset.
module path_wall_blocking_check_top #(
  parameter int MaxWalls  = pwbc_pkg::MaxWalls
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  pwbc_pkg::in_item_t  in_item_i,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output pwbc_pkg::out_item_t out_item_o
);
  logic cmd_empty, cmd_take, res_valid, res_full;
  pwbc_pkg::in_item_t cmd;
  pwbc_pkg::out_item_t res;

  pwbc_queue #(.Depth(pwbc_pkg::QueueDepth), .Width($bits(pwbc_pkg::in_item_t))) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item_i), .full_o(full),
    .pop_i(cmd_take), .data_o(cmd), .empty_o(cmd_empty)
  );

  pwbc_back #(.MaxWalls(MaxWalls)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(!cmd_empty), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res), .res_full_i(res_full)
  );

  pwbc_queue #(.Depth(pwbc_pkg::QueueDepth), .Width($bits(pwbc_pkg::out_item_t))) u_out_q (
    .clk_i, .rst_ni, .push_i(res_valid), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );
endmodule

// ===== hw/rtl/pwbc_queue.sv =====
// Short queue that carries beats between the front and back parts.
`timescale 1ns / 1ps
module pwbc_queue #(
  parameter int Depth = pwbc_pkg::QueueDepth,
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0]  mem_q [Depth];
  logic [AddrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AddrBits:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (AddrBits+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = (wr_q == AddrBits'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AddrBits'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (AddrBits+1)'(do_push) - (AddrBits+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (AddrBits+1)'(Depth))
    else $error("Queue count exceeds depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("Queue count did not grow on push.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !full_o)
    else $error("Queue is both empty and full.");
endmodule

// ===== hw/rtl/pwbc_back.sv =====
// Back part: wall tables, load and clear handling, and the query scan.
`timescale 1ns / 1ps
module pwbc_back #(
  parameter int MaxWalls  = pwbc_pkg::MaxWalls
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  pwbc_pkg::in_item_t   cmd_i,
  output logic                 cmd_take_o,
  output logic                 res_valid_o,
  output pwbc_pkg::out_item_t  res_o,
  input  logic                 res_full_i
);
  localparam int Cb = pwbc_pkg::CoordBits;
  localparam int AddrBits = (MaxWalls > 1) ? $clog2(MaxWalls) : 1;
  localparam int CntBits = $clog2(MaxWalls + 1);
  localparam int DBits = Cb + 2;
  localparam int PBits = 2 * DBits;

  typedef struct packed {
    logic signed [Cb-1:0] sx;
    logic signed [Cb-1:0] sy;
    logic signed [Cb-1:0] ex;
    logic signed [Cb-1:0] ey;
  } wall_t;

  wall_t vmem_q [MaxWalls];
  wall_t hmem_q [MaxWalls];
  wall_t vrd_q, hrd_q;

  pwbc_pkg::state_e state_q, state_d;
  logic [CntBits-1:0] vcnt_q, vcnt_d, hcnt_q, hcnt_d;
  logic [CntBits-1:0] idx_q, idx_d;
  logic horiz_q, horiz_d;
  logic cr_q, cr_d, bh_q, bh_d;
  pwbc_pkg::in_item_t cmd_q;
  logic rd_pend_q, rd_pend_d;
  wall_t cur_q;
  logic cur_h_q, cur_v_q;

  logic signed [DBits-1:0] vx, vy, ux, uy, e, f;
  logic signed [PBits-1:0] p_ux_vy_q, p_vx_uy_q, p_ux_f_q, p_e_uy_q, p_vx_f_q, p_e_vy_q;
  logic st2_v_q, bh_hit_q;
  logic signed [PBits:0] det, n1, n2;
  logic cross_hit;
  logic signed [Cb-1:0] dep, wa, wb, pq, ps, lo, hi;
  logic signed [Cb:0] ad, aq;
  logic same, bh_hit;
  logic take, vfull, hfull, scan_end;
  pwbc_pkg::out_item_t res_d;
  logic res_we;

  assign vfull = (vcnt_q == CntBits'(MaxWalls));
  assign hfull = (hcnt_q == CntBits'(MaxWalls));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwbc_pkg::ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          if (pwbc_pkg::action_e'(cmd_i.action) == pwbc_pkg::ACT_QUERY) begin
            state_d = pwbc_pkg::ST_SCAN;
          end
        end
      end
      pwbc_pkg::ST_SCAN: begin
        if (scan_end) state_d = pwbc_pkg::ST_READ;
      end
      pwbc_pkg::ST_READ: begin
        if (!rd_pend_q && !cur_v_q && !st2_v_q) state_d = pwbc_pkg::ST_DONE;
      end
      pwbc_pkg::ST_DONE: begin
        if (!res_full_i) state_d = pwbc_pkg::ST_IDLE;
      end
      default: state_d = pwbc_pkg::ST_IDLE;
    endcase
  end

  assign scan_end = horiz_q && (idx_q >= hcnt_q);

  always_comb begin
    take      = 1'b0;
    res_we    = 1'b0;
    res_d     = '0;
    vcnt_d    = vcnt_q;
    hcnt_d    = hcnt_q;
    idx_d     = idx_q;
    horiz_d   = horiz_q;
    rd_pend_d = 1'b0;
    cr_d      = cr_q | (st2_v_q && cross_hit);
    bh_d      = bh_q | (st2_v_q && bh_hit_q);
    unique case (state_q)
      pwbc_pkg::ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          take = 1'b1;
          unique case (pwbc_pkg::action_e'(cmd_i.action))
            pwbc_pkg::ACT_LOAD_V: begin
              res_we = 1'b1;
              res_d.accepted = !vfull;
              res_d.table_full = vfull;
              if (!vfull) vcnt_d = vcnt_q + 1'b1;
            end
            pwbc_pkg::ACT_LOAD_H: begin
              res_we = 1'b1;
              res_d.accepted = !hfull;
              res_d.table_full = hfull;
              if (!hfull) hcnt_d = hcnt_q + 1'b1;
            end
            pwbc_pkg::ACT_CLEAR: begin
              res_we = 1'b1;
              res_d.accepted = 1'b1;
              vcnt_d = '0;
              hcnt_d = '0;
            end
            pwbc_pkg::ACT_QUERY: begin
              idx_d = '0;
              horiz_d = 1'b0;
              cr_d = 1'b0;
              bh_d = 1'b0;
            end
            default: ;
          endcase
          res_d.vertical_count = pwbc_pkg::CountBits'(vcnt_d);
          res_d.horizontal_count = pwbc_pkg::CountBits'(hcnt_d);
        end
      end
      pwbc_pkg::ST_SCAN: begin
        if (!horiz_q) begin
          if (idx_q >= vcnt_q) begin
            horiz_d = 1'b1;
            idx_d = '0;
          end else begin
            rd_pend_d = 1'b1;
            idx_d = idx_q + 1'b1;
          end
        end else if (idx_q < hcnt_q) begin
          rd_pend_d = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      pwbc_pkg::ST_DONE: begin
        if (!res_full_i) begin
          res_we = 1'b1;
          res_d.accepted = 1'b1;
          res_d.crosses_wall = cr_q;
          res_d.behind_wall = bh_q;
          res_d.blocked = cr_q | bh_q;
          res_d.vertical_count = pwbc_pkg::CountBits'(vcnt_q);
          res_d.horizontal_count = pwbc_pkg::CountBits'(hcnt_q);
        end
      end
      default: ;
    endcase
  end

  assign cmd_take_o  = take;
  assign res_valid_o = res_we;
  assign res_o       = res_d;

  always_ff @(posedge clk_i) begin
    if (take && pwbc_pkg::action_e'(cmd_i.action) == pwbc_pkg::ACT_LOAD_V && !vfull) begin
      vmem_q[vcnt_q[AddrBits-1:0]] <= {cmd_i.seg_start_x, cmd_i.seg_start_y,
                                        cmd_i.seg_end_x, cmd_i.seg_end_y};
    end
    if (take && pwbc_pkg::action_e'(cmd_i.action) == pwbc_pkg::ACT_LOAD_H && !hfull) begin
      hmem_q[hcnt_q[AddrBits-1:0]] <= {cmd_i.seg_start_x, cmd_i.seg_start_y,
                                        cmd_i.seg_end_x, cmd_i.seg_end_y};
    end
    vrd_q <= vmem_q[idx_q[AddrBits-1:0]];
    hrd_q <= hmem_q[idx_q[AddrBits-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    cur_q <= horiz_q ? hrd_q : vrd_q;
    cur_h_q <= horiz_q;
  end

  always_comb begin
    vx = DBits'(cmd_q.seg_end_x) - DBits'(cmd_q.seg_start_x);
    vy = DBits'(cmd_q.seg_end_y) - DBits'(cmd_q.seg_start_y);
    ux = DBits'(cur_q.ex) - DBits'(cur_q.sx);
    uy = DBits'(cur_q.ey) - DBits'(cur_q.sy);
    e  = DBits'(cur_q.sx) - DBits'(cmd_q.seg_start_x);
    f  = DBits'(cur_q.sy) - DBits'(cmd_q.seg_start_y);
    dep = cur_h_q ? cur_q.sy : cur_q.sx;
    wa  = cur_h_q ? cur_q.sx : cur_q.sy;
    wb  = cur_h_q ? cur_q.ex : cur_q.ey;
    pq  = cur_h_q ? cmd_q.point_y : cmd_q.point_x;
    ps  = cur_h_q ? cmd_q.point_x : cmd_q.point_y;
    lo  = (wa < wb) ? wa : wb;
    hi  = (wa < wb) ? wb : wa;
    same = (dep < 0 && pq < 0) || (dep > 0 && pq > 0);
    ad = dep[Cb-1] ? -(Cb+1)'(dep) : (Cb+1)'(dep);
    aq = pq[Cb-1] ? -(Cb+1)'(pq) : (Cb+1)'(pq);
    bh_hit = same && (aq > ad) && (ps > lo) && (ps < hi);
  end

  always_ff @(posedge clk_i) begin
    p_ux_vy_q <= ux * vy;
    p_vx_uy_q <= vx * uy;
    p_ux_f_q  <= ux * f;
    p_e_uy_q  <= e * uy;
    p_vx_f_q  <= vx * f;
    p_e_vy_q  <= e * vy;
    bh_hit_q  <= bh_hit;
  end

  always_comb begin
    det = (PBits+1)'(p_ux_vy_q) - (PBits+1)'(p_vx_uy_q);
    n1  = (PBits+1)'(p_ux_f_q) - (PBits+1)'(p_e_uy_q);
    n2  = (PBits+1)'(p_vx_f_q) - (PBits+1)'(p_e_vy_q);
    if (det > 0) begin
      cross_hit = (n1 >= 0) && (n1 <= det) && (n2 >= 0) && (n2 <= det);
    end else if (det < 0) begin
      cross_hit = (n1 <= 0) && (n1 >= det) && (n2 <= 0) && (n2 >= det);
    end else begin
      cross_hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pwbc_pkg::ST_IDLE;
      vcnt_q    <= '0;
      hcnt_q    <= '0;
      idx_q     <= '0;
      horiz_q   <= 1'b0;
      cr_q      <= 1'b0;
      bh_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      cur_v_q   <= 1'b0;
      st2_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      vcnt_q    <= vcnt_d;
      hcnt_q    <= hcnt_d;
      idx_q     <= idx_d;
      horiz_q   <= horiz_d;
      cr_q      <= cr_d;
      bh_q      <= bh_d;
      rd_pend_q <= rd_pend_d;
      cur_v_q   <= rd_pend_q;
      st2_v_q   <= cur_v_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= CntBits'(MaxWalls) && hcnt_q <= CntBits'(MaxWalls))
    else $error("Wall count exceeds table size.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !res_full_i)
    else $error("Result written into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pwbc_pkg::ST_IDLE) |-> !cmd_take_o)
    else $error("Command taken while a query is running.");
endmodule
